>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; all checks sample on clk and are
// held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/scrd_pkg.sv
// ----------------------------------------------------------------------------
// scrd_pkg
// Types, constants and step functions of the stick calibration pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scrd_pkg;

    // Q2.14 unity
    localparam logic [14:0] Q_ONE = 15'd16384;

    // divider: one entry stage (overflow check) plus one stage per quotient bit
    localparam int DIV_BITS   = 15;
    localparam int DIV_STAGES = DIV_BITS + 1;

    // root: square stage, sum stage, one stage per root bit
    localparam int SQRT_BITS   = 15;
    localparam int SQRT_STAGES = SQRT_BITS + 2;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_RANGE_X   = 3'd2,
        REG_RANGE_Y   = 3'd3,
        REG_DRIFT_THR = 3'd4
    } cfg_reg_t;

    // one divider lane
    typedef struct packed {
        logic [30:0] rem;
        logic [14:0] quo;
        logic        ovf;
        logic [14:0] den;
    } div_lane_t;

    // root lane
    typedef struct packed {
        logic [29:0] rem;
        logic [28:0] sq;
        logic [14:0] root;
    } sq_lane_t;

    // load numerator (scaled by 2^14) and flag a quotient of 2^15 or more
    function automatic div_lane_t div_init(input logic [16:0] num, input logic [14:0] den);
        div_lane_t r;
        r.rem = {num, 14'b0};
        r.quo = '0;
        r.den = den;
        r.ovf = (r.rem >= {1'b0, den, 15'b0});
        return r;
    endfunction

    // one restoring step for quotient bit k
    function automatic div_lane_t div_step(input div_lane_t a, input int k);
        div_lane_t   r;
        logic [30:0] trial;
        r     = a;
        trial = 31'(a.den) << k;
        if (a.rem >= trial)
        begin
            r.rem = a.rem - trial;
            r.quo = a.quo | (15'd1 << k);
        end
        return r;
    endfunction

    // one digit step of the integer root for bit k
    function automatic sq_lane_t sq_step(input sq_lane_t a, input int k);
        sq_lane_t    r;
        logic [30:0] trial;
        r     = a;
        trial = (31'(a.root) << (k + 1)) + (31'd1 << (2 * k));
        if (31'(a.rem) >= trial)
        begin
            r.rem  = 30'(31'(a.rem) - trial);
            r.root = a.root | (15'd1 << k);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/scrd_div2.sv
// ----------------------------------------------------------------------------
// scrd_div2
// Two-lane pipelined restoring divider: quo = (num * 2^14) / den, one bit
// per stage, with a flag for quotients of 2^15 or more.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scrd_div2 #(
    parameter int SIDE_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [16:0]       num_x,
    input  logic [14:0]       den_x,
    input  logic [16:0]       num_y,
    input  logic [14:0]       den_y,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [14:0]       quo_x,
    output logic              ovf_x,
    output logic [14:0]       quo_y,
    output logic              ovf_y,
    output logic [SIDE_W-1:0] side_out
);

    localparam int NS = scrd_pkg::DIV_STAGES;

    logic [NS-1:0]       v_reg;
    logic [NS-1:0]       v_prev;
    logic [NS:0]         en;
    scrd_pkg::div_lane_t lx_reg  [NS];
    scrd_pkg::div_lane_t ly_reg  [NS];
    scrd_pkg::div_lane_t lx_next [NS];
    scrd_pkg::div_lane_t ly_next [NS];
    logic [SIDE_W-1:0]   side_reg [NS];

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        en[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s + 1];
        end
    end

    assign in_ready = en[0];
    assign v_prev   = {v_reg[NS-2:0], in_valid};

    // stage datapath
    always_comb
    begin
        lx_next[0] = scrd_pkg::div_init(num_x, den_x);
        ly_next[0] = scrd_pkg::div_init(num_y, den_y);
        for (int s = 1; s < NS; s++)
        begin
            lx_next[s] = scrd_pkg::div_step(lx_reg[s - 1], NS - 1 - s);
            ly_next[s] = scrd_pkg::div_step(ly_reg[s - 1], NS - 1 - s);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_prev[s];
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side_in;
        end
        for (int s = 0; s < NS; s++)
        begin
            if (en[s])
            begin
                lx_reg[s] <= lx_next[s];
                ly_reg[s] <= ly_next[s];
            end
        end
        for (int s = 1; s < NS; s++)
        begin
            if (en[s])
            begin
                side_reg[s] <= side_reg[s - 1];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign quo_x     = lx_reg[NS-1].quo;
    assign ovf_x     = lx_reg[NS-1].ovf;
    assign quo_y     = ly_reg[NS-1].quo;
    assign ovf_y     = ly_reg[NS-1].ovf;
    assign side_out  = side_reg[NS-1];

endmodule

>>> hw/rtl/scrd_isqrt.sv
// ----------------------------------------------------------------------------
// scrd_isqrt
// Pipelined vector magnitude: squares, sum, then floor root one bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scrd_isqrt #(
    parameter int SIDE_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [14:0]       mag_x,
    input  logic [14:0]       mag_y,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [14:0]       root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int NS = scrd_pkg::SQRT_STAGES;

    logic [NS-1:0]      v_reg;
    logic [NS-1:0]      v_prev;
    logic [NS:0]        en;
    scrd_pkg::sq_lane_t l_reg  [NS];
    scrd_pkg::sq_lane_t l_next [NS];
    logic [SIDE_W-1:0]  side_reg [NS];
    logic [29:0]        sq_x;
    logic [29:0]        sq_y;

    // stall chain
    always_comb
    begin
        en[NS] = out_ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s + 1];
        end
    end

    assign in_ready = en[0];
    assign v_prev   = {v_reg[NS-2:0], in_valid};

    // squares of 15-bit magnitudes
    assign sq_x = {15'b0, mag_x} * {15'b0, mag_x};
    assign sq_y = {15'b0, mag_y} * {15'b0, mag_y};

    // stage datapath
    always_comb
    begin
        l_next[0].rem  = sq_x;
        l_next[0].sq   = sq_y[28:0];
        l_next[0].root = '0;
        l_next[1].rem  = l_reg[0].rem + 30'(l_reg[0].sq);
        l_next[1].sq   = '0;
        l_next[1].root = '0;
        for (int s = 2; s < NS; s++)
        begin
            l_next[s] = scrd_pkg::sq_step(l_reg[s - 1], NS - 1 - s);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_prev[s];
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side_in;
        end
        for (int s = 0; s < NS; s++)
        begin
            if (en[s])
            begin
                l_reg[s] <= l_next[s];
            end
        end
        for (int s = 1; s < NS; s++)
        begin
            if (en[s])
            begin
                side_reg[s] <= side_reg[s - 1];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign root      = l_reg[NS-1].root;
    assign side_out  = side_reg[NS-1];

endmodule

>>> hw/rtl/stick_center_range_deadzone.sv
// ----------------------------------------------------------------------------
// stick_center_range_deadzone
// Analog stick calibration: center, range, radial clamp and drift dead zone.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one raw_x/raw_y sample in Q2.14
//   per transfer; output channel (out_valid/out_ready) returns cal_x/cal_y.
//   Every sample gives exactly one result, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the two
//   centers, the two ranges and the drift threshold; always ready. Unknown
//   indexes are dropped. Write only while the pipeline is empty.
//   Pipeline: 16 stages of the axis divider, 17 of the magnitude (square, sum,
//   one root bit a stage), 16 of the normalizing divider.
//   Throughput: one sample per cycle while out_ready is high; every stage holds one sample.
//   Stall: a stage moves only when empty or when its successor moves, so a
//   stalled receiver fills the bubbles and then holds in_ready low; nothing
//   is lost or repeated.
//   Reset: pipeline empties, centers 0, ranges 1.0, threshold 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stick_center_range_deadzone (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] cal_x,
    output logic signed [15:0] cal_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic signed [15:0] ctr_x_reg;
    logic signed [15:0] ctr_y_reg;
    logic [14:0]        range_x_reg;
    logic [14:0]        range_y_reg;
    logic [14:0]        drift_thr_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_x_reg     <= '0;
            ctr_y_reg     <= '0;
            range_x_reg   <= scrd_pkg::Q_ONE;
            range_y_reg   <= scrd_pkg::Q_ONE;
            drift_thr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (scrd_pkg::cfg_reg_t'(cfg_index))
                scrd_pkg::REG_CENTER_X:  ctr_x_reg     <= cfg_data;
                scrd_pkg::REG_CENTER_Y:  ctr_y_reg     <= cfg_data;
                scrd_pkg::REG_RANGE_X:   range_x_reg   <= cfg_data[14:0];
                scrd_pkg::REG_RANGE_Y:   range_y_reg   <= cfg_data[14:0];
                scrd_pkg::REG_DRIFT_THR: drift_thr_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // centering: 17-bit difference, split into sign and magnitude
    logic [16:0] dx;
    logic [16:0] dy;
    logic [16:0] ax;
    logic [16:0] ay;

    assign dx = {raw_x[15], raw_x} - {ctr_x_reg[15], ctr_x_reg};
    assign dy = {raw_y[15], raw_y} - {ctr_y_reg[15], ctr_y_reg};
    assign ax = dx[16] ? (17'd0 - dx) : dx;
    assign ay = dy[16] ? (17'd0 - dy) : dy;

    // axis divide by range
    logic        d1_valid;
    logic        d1_ready;
    logic [14:0] d1_quo_x;
    logic [14:0] d1_quo_y;
    logic        d1_ovf_x;
    logic        d1_ovf_y;
    logic [3:0]  d1_side;

    scrd_div2 #(
        .SIDE_W (4)
    ) u_axis_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .num_x     (ax),
        .den_x     (range_x_reg),
        .num_y     (ay),
        .den_y     (range_y_reg),
        .side_in   ({dx[16], (dx == 17'd0), dy[16], (dy == 17'd0)}),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .quo_x     (d1_quo_x),
        .ovf_x     (d1_ovf_x),
        .quo_y     (d1_quo_y),
        .ovf_y     (d1_ovf_y),
        .side_out  (d1_side)
    );

    // clamp to unity; a zero difference stays zero even with zero range
    logic [14:0] mx;
    logic [14:0] my;

    assign mx = d1_side[2] ? 15'd0 :
                (d1_ovf_x || (d1_quo_x > scrd_pkg::Q_ONE)) ? scrd_pkg::Q_ONE : d1_quo_x;
    assign my = d1_side[0] ? 15'd0 :
                (d1_ovf_y || (d1_quo_y > scrd_pkg::Q_ONE)) ? scrd_pkg::Q_ONE : d1_quo_y;

    // magnitude
    logic        sq_valid;
    logic        sq_ready;
    logic [14:0] mag;
    logic [31:0] sq_side;

    scrd_isqrt #(
        .SIDE_W (32)
    ) u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .mag_x     (mx),
        .mag_y     (my),
        .side_in   ({d1_side[3], mx, d1_side[1], my}),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .root      (mag),
        .side_out  (sq_side)
    );

    // radial clamp: divide by the magnitude above unity, else by unity
    logic        norm;
    logic [14:0] norm_den;
    logic [14:0] mag_eff;
    logic        snap;

    assign norm     = mag > scrd_pkg::Q_ONE;
    assign norm_den = norm ? mag : scrd_pkg::Q_ONE;
    assign mag_eff  = norm ? scrd_pkg::Q_ONE : mag;
    assign snap     = mag_eff <= drift_thr_reg;

    logic [14:0] d2_quo_x;
    logic [14:0] d2_quo_y;
    logic        d2_ovf_x;
    logic        d2_ovf_y;
    logic [2:0]  d2_side;

    scrd_div2 #(
        .SIDE_W (3)
    ) u_norm_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .num_x     ({2'b0, sq_side[30:16]}),
        .den_x     (norm_den),
        .num_y     ({2'b0, sq_side[14:0]}),
        .den_y     (norm_den),
        .side_in   ({sq_side[31], sq_side[15], snap}),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quo_x     (d2_quo_x),
        .ovf_x     (d2_ovf_x),
        .quo_y     (d2_quo_y),
        .ovf_y     (d2_ovf_y),
        .side_out  (d2_side)
    );

    // dead zone and sign
    logic [15:0] res_x;
    logic [15:0] res_y;

    assign res_x = d2_side[2] ? (16'd0 - {1'b0, d2_quo_x}) : {1'b0, d2_quo_x};
    assign res_y = d2_side[1] ? (16'd0 - {1'b0, d2_quo_y}) : {1'b0, d2_quo_y};
    assign cal_x = d2_side[0] ? 16'sd0 : signed'(res_x);
    assign cal_y = d2_side[0] ? 16'sd0 : signed'(res_y);

    // checks
    logic cal_in_range;

    assign cal_in_range = (cal_x <= 16'sd16384) && (cal_x >= -16'sd16384)
                          && (cal_y <= 16'sd16384) && (cal_y >= -16'sd16384);

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_cal_range, !out_valid || cal_in_range)
    `ASSERT_ALWAYS(a_no_norm_ovf, !out_valid || (!d2_ovf_x && !d2_ovf_y))
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cal_x) && $stable(cal_y))

endmodule

>>> tb/scrd_checker.sv
// ----------------------------------------------------------------------------
// scrd_checker
// Watches the sample, result and register channels of the stick calibration
// block, predicts each calibrated sample and compares it with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scrd_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] cal_x,
    input  logic signed [15:0] cal_y,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam longint ONE = 16384;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } stick_t;

    // shadow copy of the calibration registers
    logic signed [15:0] ctr_x, ctr_y;
    logic [14:0]        rng_x, rng_y, drift_thr;

    stick_t cal_queue[$];

    assign pending = cal_queue.size();

    // center, scale by range, clamp to +-1
    function automatic longint scale_axis(longint raw, longint ctr, longint rng);
        longint d, q;
        d = raw - ctr;
        if (rng == 0)
            q = (d > 0) ? ONE : ((d < 0) ? -ONE : 0);
        else
            q = (d * ONE) / rng;
        if (q > ONE) q = ONE;
        if (q < -ONE) q = -ONE;
        return q;
    endfunction

    // floor of the square root, found bit by bit
    function automatic longint floor_root(longint v);
        longint r;
        r = 0;
        for (int b = 15; b >= 0; b--)
            if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v)
                r = r + (64'd1 << b);
        return r;
    endfunction

    function automatic stick_t calibrate(logic signed [15:0] rx, logic signed [15:0] ry);
        longint cx, cy, m;
        stick_t s;
        cx = scale_axis(rx, ctr_x, rng_x);
        cy = scale_axis(ry, ctr_y, rng_y);
        m  = floor_root(cx * cx + cy * cy);
        // pull back onto the unit circle
        if (m > ONE)
        begin
            cx = (cx * ONE) / m;
            cy = (cy * ONE) / m;
            m  = ONE;
        end
        // drift dead zone
        if (m <= drift_thr)
        begin
            cx = 0;
            cy = 0;
        end
        s.x = 16'(cx);
        s.y = 16'(cy);
        return s;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stick_t e;
        if (!rst_n)
        begin
            ctr_x      = '0;
            ctr_y      = '0;
            rng_x      = 15'd16384;
            rng_y      = 15'd16384;
            drift_thr  = '0;
            fail_count = 0;
            cal_queue.delete();
        end
        else
        begin
            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    scrd_pkg::REG_CENTER_X:  ctr_x     = cfg_data;
                    scrd_pkg::REG_CENTER_Y:  ctr_y     = cfg_data;
                    scrd_pkg::REG_RANGE_X:   rng_x     = cfg_data[14:0];
                    scrd_pkg::REG_RANGE_Y:   rng_y     = cfg_data[14:0];
                    scrd_pkg::REG_DRIFT_THR: drift_thr = cfg_data[14:0];
                    default: ;
                endcase
            end
            // sample transfer
            if (in_valid && in_ready)
                cal_queue.push_back(calibrate(raw_x, raw_y));
            // result transfer
            if (out_valid && out_ready)
            begin
                if (cal_queue.size() == 0)
                    report_mismatch("unexpected result", cal_x, 0);
                else
                begin
                    e = cal_queue.pop_front();
                    if (cal_x !== e.x) report_mismatch("cal_x", cal_x, e.x);
                    if (cal_y !== e.y) report_mismatch("cal_y", cal_y, e.y);
                end
            end
        end
    end

endmodule

>>> tb/tb_stick_center_range_deadzone.sv
// ----------------------------------------------------------------------------
// tb_stick_center_range_deadzone
// Drives directed and random stick samples through several register settings
// with random stalls on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stick_center_range_deadzone;

    localparam int LATENCY   = 49;
    localparam int MAX_CYCLE = 400000;

    logic               clk, rst_n;
    logic               in_valid, in_ready;
    logic signed [15:0] raw_x, raw_y;
    logic               out_valid, out_ready;
    logic signed [15:0] cal_x, cal_y;
    logic               cfg_valid, cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    int                 fail_count, pending;
    int                 cycle = 0;
    int                 rx_hold;
    bit                 rx_steady;

    stick_center_range_deadzone u_top (.*);

    scrd_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // receiver: random stalls, mostly short, some long, some steady stretches
    always @(posedge clk)
    begin
        if (!rst_n || rx_steady)
        begin
            out_ready <= 1'b1;
            rx_hold   <= 0;
        end
        else if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= gap_len();
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // valid stays high between back-to-back samples; drain() drops it
    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_x    <= x;
        raw_y    <= y;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(scrd_pkg::cfg_reg_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_regs(int cx, int cy, int rx, int ry, int thr);
        write_reg(scrd_pkg::REG_CENTER_X, 16'(cx));
        write_reg(scrd_pkg::REG_CENTER_Y, 16'(cy));
        write_reg(scrd_pkg::REG_RANGE_X, 16'(rx));
        write_reg(scrd_pkg::REG_RANGE_Y, 16'(ry));
        write_reg(scrd_pkg::REG_DRIFT_THR, 16'(thr));
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(0, 600)) - 16'sd300;
            2:       return ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)
                            + 16'($urandom_range(0, 40)) - 16'sd20;
            default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            send_sample(rand_axis(), rand_axis(), i % 60 >= 20);
            rx_steady = (i % 80) >= 70;
        end
        rx_steady = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        raw_x     = '0;
        raw_y     = '0;
        cfg_valid = 1'b0;
        cfg_index = scrd_pkg::REG_CENTER_X;
        cfg_data  = '0;
        rx_steady = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, field extremes, zero, near-unit magnitudes
        send_sample(16'sh7FFF, 16'sh7FFF, 0);
        send_sample(-16'sh8000, -16'sh8000, 0);
        send_sample(16'sh7FFF, -16'sh8000, 0);
        send_sample(0, 0, 0);
        send_sample(16'sd16384, 0, 0);
        send_sample(11585, 11585, 0);
        send_sample(11586, 11586, 0);
        send_sample(-11586, 11585, 0);
        send_sample(1, -1, 0);
        // hold off until the pipeline is empty
        drain();

        // zero ranges saturate, extreme centers widen the difference
        set_regs(-16384, 16384, 0, 0, 0);
        send_sample(16'sh7FFF, -16'sh8000, 0);
        send_sample(-16384, 16384, 0);
        send_sample(-16'sh8000, 16'sh7FFF, 0);
        send_sample(0, 0, 0);
        drain();

        // a large and a tiny range, and threshold at and above one
        set_regs(16384, -16384, 32767, 1, 16384);
        send_sample(16'sh7FFF, 16'sh7FFF, 0);
        send_sample(16384, -16384, 0);
        drain();
        write_reg(scrd_pkg::REG_DRIFT_THR, 16'h7FFF);
        send_sample(-16'sh8000, 16'sh7FFF, 0);
        drain();
        set_regs(0, 0, 16384, 16384, 100);
        send_sample(100, 0, 0);
        send_sample(101, 0, 0);
        send_sample(70, 71, 0);
        send_sample(0, -16'sh8000, 0);
        drain();

        // random phases over several settings
        random_phase(100);
        drain();
        set_regs($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                 $urandom_range(8000, 20000), $urandom_range(8000, 20000),
                 $urandom_range(0, 2000));
        random_phase(100);
        drain();
        set_regs($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                 $urandom_range(0, 32767), $urandom_range(0, 32767),
                 $urandom_range(0, 16384));
        random_phase(100);
        drain();
        set_regs(0, 0, $urandom_range(0, 3), 32767, $urandom_range(0, 32767));
        random_phase(100);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
